@@ sv/bta_pkg.sv @@
// Shared constants, types and helpers for the bitmap tag allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package bta_pkg;

   localparam int TAG_CAP    = 1024;
   localparam int REQUESTERS = 8;
   localparam int WORD_BITS  = 64;
   localparam int NUM_WORDS  = (TAG_CAP + WORD_BITS - 1) / WORD_BITS;

   localparam int TAG_W  = 10;                 // tag field width
   localparam int CNT_W  = 11;                 // tag limit register width
   localparam int REQ_W  = 3;                  // requester field width
   localparam int BIT_W  = $clog2(WORD_BITS);  // bit index inside a word
   localparam int ADDR_W = $clog2(NUM_WORDS);  // word address
   localparam int PROD_W = REQ_W + CNT_W;      // r * tag limit

   localparam logic [CNT_W-1:0] TAG_CAP_VAL = CNT_W'(TAG_CAP);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

   // bounds applied to one bitmap word while searching
   typedef struct packed {
      logic [ADDR_W-1:0] word;
      logic              lo_en;   // only bits at or above bound
      logic              hi_en;   // only bits below bound
      logic [BIT_W-1:0]  bound;
   } scan_cfg_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } scan_res_type;

   typedef struct packed {
      logic             en;
      logic [REQ_W-1:0] idx;
      logic [TAG_W-1:0] value;
   } hint_wr_type;

   typedef struct packed {
      logic             en;
      logic [CNT_W-1:0] limit;
   } reseed_type;

   // hint seed for requester r: r * tag limit / REQUESTERS
   function automatic logic [TAG_W-1:0] seed_hint(input logic [REQ_W-1:0] r,
                                                  input logic [CNT_W-1:0] m);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(r) * PROD_W'(m);
      return TAG_W'(prod / REQUESTERS);
   endfunction

endpackage
`default_nettype wire

@@ sv/bta_word_ram.sv @@
// Bitmap storage: one word per row, registered read, one write port.
// Per-row valid bits make a cleared row read as all free. Uses bta_pkg.
`default_nettype none
module bta_word_ram
   import bta_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clear,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output logic      [WORD_BITS-1:0] rd_data,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] vld_ff, vld_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   // track written rows; clear drops them all at once
   always_comb begin
      vld_in = vld_ff;
      if (clear) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // array write and registered read; hold read data when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

@@ sv/bta_word_scan.sv @@
// Finds the lowest free tag bit of one bitmap word within its bounds.
// Pure logic; uses bta_pkg.
`default_nettype none
module bta_word_scan
   import bta_pkg::*;
(
   input  wire logic [WORD_BITS-1:0] data,
   input  wire logic [CNT_W-1:0]     tag_limit,
   input  wire scan_cfg_type         cfg,
   output scan_res_type              res
);

   localparam int HI_W = CNT_W - BIT_W;

   logic [WORD_BITS-1:0] free_vec;
   logic [HI_W-1:0]      max_hi;
   logic [BIT_W-1:0]     max_lo;

   assign max_hi = tag_limit[CNT_W-1:BIT_W];
   assign max_lo = tag_limit[BIT_W-1:0];

   // mark each bit free if clear, below the tag limit and inside the bounds
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         free_vec[i] = !data[i]
            && ((max_hi > HI_W'(cfg.word)) || (BIT_W'(i) < max_lo))
            && (!cfg.lo_en || (BIT_W'(i) >= cfg.bound))
            && (!cfg.hi_en || (BIT_W'(i) < cfg.bound));
      end
   end

   // pick the lowest free bit
   always_comb begin
      res = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            res.found = 1'b1;
            res.idx   = BIT_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

@@ sv/bta_hint_table.sv @@
// Per-requester next-search hints, seeded from the tag limit on reset and
// on every register write. Uses bta_pkg.
`default_nettype none
module bta_hint_table
   import bta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire reseed_type       reseed,
   input  wire hint_wr_type      wr,
   input  wire logic [REQ_W-1:0] rd_idx,
   output logic      [TAG_W-1:0] rd_hint
);

   logic [TAG_W-1:0] hint_ff [REQUESTERS];
   logic [TAG_W-1:0] hint_in [REQUESTERS];

   // reseed all, or update the one requester
   always_comb begin
      for (int r = 0; r < REQUESTERS; r++) begin
         if (reseed.en) begin
            hint_in[r] = seed_hint(REQ_W'(r), reseed.limit);
         end else if (wr.en && (wr.idx == REQ_W'(r))) begin
            hint_in[r] = wr.value;
         end else begin
            hint_in[r] = hint_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < REQUESTERS; r++) begin
         if (reset) begin
            hint_ff[r] <= seed_hint(REQ_W'(r), TAG_CAP_VAL);
         end else begin
            hint_ff[r] <= hint_in[r];
         end
      end
   end

   assign rd_hint = hint_ff[rd_idx];

endmodule
`default_nettype wire

@@ sv/bitmap_tag_allocator.sv @@
// Top level of the bitmap tag allocator: control sequencer, register,
// result buffer. Uses bta_pkg, bta_word_ram, bta_word_scan, bta_hint_table.
//
//   channel | ports                               | direction
//   req     | req_valid/ready, kind, requester,   | in
//           | tag_in                              |
//   rsp     | rsp_valid/ready, tag_out, ok        | out
//   csr     | csr_valid/ready, tag_limit          | in (register write)
//
// A free is accepted, then does one read-modify-write of its word.
// An allocate searches from the word of its hint up to word W = (tag_limit-1)/64 and wraps:
// the search reads one bitmap word per cycle from the single RAM read port while the
// result register is free, visiting the start word a second time for bits below the hint.
// Reset and register writes clear the bitmap at once through row valid bits.
// A finished result waits in the output register; the next beat may be
// accepted meanwhile, and its completion holds until the register frees up.
`default_nettype none
module bitmap_tag_allocator
   import bta_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_kind,
   input  wire logic [REQ_W-1:0] req_requester,
   input  wire logic [TAG_W-1:0] req_tag_in,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [TAG_W-1:0] rsp_tag_out,
   output logic                  rsp_ok,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CNT_W-1:0] csr_tag_limit
);

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [REQ_W-1:0]  req_ff, req_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [ADDR_W-1:0] cur_word_ff, cur_word_in;
   logic [ADDR_W-1:0] start_word_ff, start_word_in;
   logic [BIT_W-1:0]  start_bit_ff, start_bit_in;
   logic              first_ff, first_in;
   logic              final_ff, final_in;
   logic [CNT_W-1:0]  tag_limit_ff, tag_limit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic                 req_fire, csr_fire, out_free;
   logic [CNT_W-1:0]     csr_clamped;
   logic [TAG_W-1:0]     hint_raw, start_tag;
   logic [ADDR_W-1:0]    last_word, next_word;
   logic [CNT_W-1:0]     found_next;
   logic [TAG_W-1:0]     found_tag;
   logic                 free_bad;
   logic                 respond;
   logic [TAG_W-1:0]     resp_tag;
   logic                 resp_ok;

   logic                 rd_en, wr_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data, wr_data;
   scan_cfg_type         scan_cfg;
   scan_res_type         scan_res;
   hint_wr_type          hint_wr;
   reseed_type           reseed;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // clamp register writes into 1..TAG_CAP
   always_comb begin
      if (csr_tag_limit == '0) begin
         csr_clamped = CNT_W'(1);
      end else if (csr_tag_limit > TAG_CAP_VAL) begin
         csr_clamped = TAG_CAP_VAL;
      end else begin
         csr_clamped = csr_tag_limit;
      end
   end

   assign tag_limit_in = csr_fire ? csr_clamped : tag_limit_ff;
   assign reseed       = '{en: csr_fire, limit: csr_clamped};

   // start of search: hint, or zero if it lies out of range
   assign start_tag  = ({1'b0, hint_raw} >= tag_limit_ff) ? '0 : hint_raw;
   assign last_word  = ADDR_W'((tag_limit_ff - CNT_W'(1)) >> BIT_W);
   assign next_word  = (cur_word_ff == last_word) ? '0 : cur_word_ff + ADDR_W'(1);
   assign found_tag  = {cur_word_ff, scan_res.idx};
   assign found_next = CNT_W'(found_tag) + CNT_W'(1);
   assign free_bad   = ({1'b0, tag_ff} >= tag_limit_ff);

   assign scan_cfg = '{word: cur_word_ff, lo_en: first_ff, hi_en: final_ff,
                       bound: start_bit_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (out_free && (kind_ff == KIND_FREE || scan_res.found || final_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls and item registers
   always_comb begin
      req_ready     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cur_word_ff;
      wr_en         = 1'b0;
      wr_data       = rd_data;
      hint_wr       = '{en: 1'b0, idx: req_ff, value: '0};
      respond       = 1'b0;
      resp_tag      = '0;
      resp_ok       = 1'b0;
      kind_in       = kind_ff;
      req_in        = req_ff;
      tag_in        = tag_ff;
      cur_word_in   = cur_word_ff;
      start_word_in = start_word_ff;
      start_bit_in  = start_bit_ff;
      first_in      = first_ff;
      final_in      = final_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               rd_en         = 1'b1;
               rd_addr       = (req_kind == KIND_FREE) ? req_tag_in[TAG_W-1:BIT_W]
                                                       : start_tag[TAG_W-1:BIT_W];
               kind_in       = req_kind;
               req_in        = req_requester;
               tag_in        = req_tag_in;
               cur_word_in   = rd_addr;
               start_word_in = start_tag[TAG_W-1:BIT_W];
               start_bit_in  = start_tag[BIT_W-1:0];
               first_in      = 1'b1;
               final_in      = 1'b0;
            end
         end
         ST_CHECK: begin
            if (!out_free) begin
               // hold until the result register frees up
            end else if (kind_ff == KIND_FREE) begin
               respond = 1'b1;
               if (!free_bad) begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data & ~(WORD_BITS'(1) << tag_ff[BIT_W-1:0]);
                  resp_tag = tag_ff;
                  resp_ok  = 1'b1;
               end
            end else if (scan_res.found) begin
               wr_en         = 1'b1;
               wr_data       = rd_data | (WORD_BITS'(1) << scan_res.idx);
               hint_wr.en    = 1'b1;
               hint_wr.value = (found_next >= tag_limit_ff) ? '0 : found_next[TAG_W-1:0];
               respond       = 1'b1;
               resp_tag      = found_tag;
               resp_ok       = 1'b1;
            end else if (final_ff) begin
               // no free tag anywhere: fail and reset the hint
               hint_wr.en = 1'b1;
               respond    = 1'b1;
            end else begin
               // advance to the next word, wrapping at the last one
               rd_en       = 1'b1;
               rd_addr     = next_word;
               cur_word_in = next_word;
               first_in    = 1'b0;
               final_in    = (next_word == start_word_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   assign rsp_valid_in = respond || (rsp_valid_ff && !rsp_ready);
   assign rsp_tag_in   = respond ? resp_tag : rsp_tag_ff;
   assign rsp_ok_in    = respond ? resp_ok : rsp_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tag_limit_ff <= TAG_CAP_VAL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_limit_ff <= tag_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      req_ff        <= req_in;
      tag_ff        <= tag_in;
      cur_word_ff   <= cur_word_in;
      start_word_ff <= start_word_in;
      start_bit_ff  <= start_bit_in;
      first_ff      <= first_in;
      final_ff      <= final_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tag_out = rsp_tag_ff;
   assign rsp_ok      = rsp_ok_ff;

   bta_word_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_fire),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (cur_word_ff),
      .wr_data (wr_data)
   );

   bta_word_scan u_scan (
      .data      (rd_data),
      .tag_limit (tag_limit_ff),
      .cfg       (scan_cfg),
      .res       (scan_res)
   );

   bta_hint_table u_hints (
      .clock   (clock),
      .reset   (reset),
      .reseed  (reseed),
      .wr      (hint_wr),
      .rd_idx  (req_requester),
      .rd_hint (hint_raw)
   );

endmodule
`default_nettype wire

@@ tb/bta_tag_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the bitmap tag allocator bench: keeps its own tag map and
// search hints, predicts each result beat and checks it. Depends on bta_pkg.
package bta_tag_scoreboard_pkg;
   import bta_pkg::*;

   typedef struct {
      logic [TAG_W-1:0] tag;
      logic             ok;
   } grant_type;

   class tag_scoreboard;
      bit [TAG_CAP-1:0]  tag_used;
      bit [TAG_W-1:0]    next_hint [REQUESTERS];
      int unsigned       tag_limit;
      grant_type         grants_due [$];
      int unsigned       mismatches;
      int unsigned       n_alloc, n_denied, n_freed, n_bad_free, n_settings;

      function new();
         apply_limit(CNT_W'(TAG_CAP));
      endfunction

      // clamp the new limit, free every tag, reseed the hints
      function void apply_limit(logic [CNT_W-1:0] value);
         int unsigned v;
         v = value;
         if (v == 0) v = 1;
         if (v > TAG_CAP) v = TAG_CAP;
         tag_limit = v;
         tag_used  = '0;
         for (int unsigned r = 0; r < REQUESTERS; r++)
            next_hint[r] = TAG_W'((r * v) / REQUESTERS);
         n_settings++;
      endfunction

      // random tag currently held, or -1 when the pool is empty
      function int pick_used();
         int unsigned t;
         t = $urandom_range(0, tag_limit - 1);
         for (int i = 0; i < tag_limit; i++) begin
            if (tag_used[t]) return t;
            t = (t + 1 >= tag_limit) ? 0 : t + 1;
         end
         return -1;
      endfunction

      // predict the result of one accepted request beat
      function void note_item(logic kind, logic [REQ_W-1:0] who, logic [TAG_W-1:0] tag);
         grant_type   g;
         int unsigned r, t;
         bit          found;
         r = who % REQUESTERS;
         if (kind == KIND_FREE) begin
            if (tag >= tag_limit) begin
               g.tag = '0;
               g.ok  = 1'b0;
               n_bad_free++;
            end else begin
               tag_used[tag] = 1'b0;
               g.tag = tag;
               g.ok  = 1'b1;
               n_freed++;
            end
         end else begin
            // circular search from the hint, wrapping at the limit
            t = next_hint[r];
            if (t >= tag_limit) t = 0;
            found = 1'b0;
            for (int i = 0; i < tag_limit && !found; i++) begin
               if (!tag_used[t]) found = 1'b1;
               else t = (t + 1 >= tag_limit) ? 0 : t + 1;
            end
            if (found) begin
               tag_used[t] = 1'b1;
               if (t + 1 >= tag_limit) next_hint[r] = '0;
               else next_hint[r] = TAG_W'(t + 1);
               g.tag = TAG_W'(t);
               g.ok  = 1'b1;
               n_alloc++;
            end else begin
               next_hint[r] = '0;
               g.tag = '0;
               g.ok  = 1'b0;
               n_denied++;
            end
         end
         grants_due.push_back(g);
      endfunction

      // print one line per mismatch and count it
      task report(string what, int unsigned want, int unsigned got);
         mismatches++;
         $display("%0t: error on %s: expected %0d, got %0d", $time, what, want, got);
      endtask

      // compare one result beat with the oldest prediction
      task check_result(logic [TAG_W-1:0] tag, logic ok);
         grant_type g;
         if (grants_due.size() == 0) begin
            report("result beat with nothing outstanding", 0, tag);
            return;
         end
         g = grants_due.pop_front();
         if (ok !== g.ok) report("ok", g.ok, ok);
         if (tag !== g.tag) report("tag_out", g.tag, tag);
      endtask
   endclass

endpackage

@@ tb/tb_bitmap_tag_allocator.sv @@
`timescale 1ns / 100ps
// Top of the bitmap tag allocator bench: clock, reset, request, result and
// register drivers. Depends on bta_pkg, bta_tag_scoreboard_pkg, the block.
module tb_bitmap_tag_allocator;
   import bta_pkg::*;
   import bta_tag_scoreboard_pkg::*;

   localparam int LONG_HOLD    = 300;  // cycles of result back-pressure
   localparam int HOLD_TRIGGER = 250;  // result beats before that hold
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 160;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_kind = 1'b0;
   logic [REQ_W-1:0] req_requester = '0;
   logic [TAG_W-1:0] req_tag_in = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [TAG_W-1:0] rsp_tag_out;
   logic             rsp_ok;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_tag_limit = '0;

   tag_scoreboard sb;
   bit            idle_on = 1'b1;
   int unsigned   rsp_beats = 0;
   int unsigned   hold_left = 0;
   bit            long_hold_done = 1'b0;

   bitmap_tag_allocator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_requester (req_requester),
      .req_tag_in    (req_tag_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tag_out   (rsp_tag_out),
      .rsp_ok        (rsp_ok),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_tag_limit (csr_tag_limit)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: random stall bursts, plus one long hold to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_beats++;
         if (hold_left == 0) begin
            if (!long_hold_done && rsp_beats >= HOLD_TRIGGER) begin
               hold_left = LONG_HOLD;
               long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
               hold_left = $urandom_range(1, 6);
            end
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // check every result beat taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_tag_out, rsp_ok);
   end

   // offer one request beat, with an optional idle burst first; leave valid high
   task automatic offer_item(logic kind, logic [REQ_W-1:0] who, logic [TAG_W-1:0] tag);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_requester <= who;
      req_tag_in    <= tag;
      do @(posedge clock); while (!req_ready);
      sb.note_item(kind, who, tag);
   endtask

   // drop valid and wait until every predicted beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.grants_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tag_limit(logic [CNT_W-1:0] value);
      csr_tag_limit <= value;
      csr_valid     <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.apply_limit(value);
   endtask

   initial begin
      int unsigned      settings [PHASES];
      int unsigned      alloc_pct, pick;
      int               used_tag;
      logic             item_kind;
      logic [TAG_W-1:0] item_tag;

      sb = new();
      settings = '{64, 1, 65, 2047, 2, 130, 1000, 0, 5, 1024};
      settings[7] = $urandom_range(1, 2047);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // full pool after reset: one grant per requester, frees, stale hint
      for (int r = 0; r < REQUESTERS; r++)
         offer_item(KIND_ALLOC, REQ_W'(r), (r % 2 == 1) ? TAG_W'(1023) : TAG_W'(0));
      offer_item(KIND_FREE, 3'd0, TAG_W'(1023));
      offer_item(KIND_FREE, 3'd0, TAG_W'(0));
      offer_item(KIND_FREE, 3'd6, TAG_W'(0));
      offer_item(KIND_ALLOC, 3'd0, TAG_W'(0));
      offer_item(KIND_FREE, 3'd2, TAG_W'(512));

      // zero written, taken as one tag: exhaust it, frees out of range
      drain();
      write_tag_limit('0);
      offer_item(KIND_ALLOC, 3'd5, TAG_W'(0));
      offer_item(KIND_ALLOC, 3'd5, TAG_W'(0));
      offer_item(KIND_FREE, 3'd1, TAG_W'(1));
      offer_item(KIND_FREE, 3'd1, TAG_W'(1023));
      offer_item(KIND_FREE, 3'd1, TAG_W'(0));
      offer_item(KIND_ALLOC, 3'd7, TAG_W'(0));

      // oversize write saturates; then a limit just past one word
      drain();
      write_tag_limit('1);
      offer_item(KIND_ALLOC, 3'd4, TAG_W'(0));
      drain();
      write_tag_limit(CNT_W'(65));
      offer_item(KIND_FREE, 3'd3, TAG_W'(64));
      offer_item(KIND_ALLOC, 3'd7, TAG_W'(0));
      offer_item(KIND_FREE, 3'd3, TAG_W'(65));

      // random phases, one limit each; the last two run without idling
      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_tag_limit(CNT_W'(settings[p]));
         idle_on   = (p >= PHASES - 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
         alloc_pct = $urandom_range(40, 90);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item_kind = ($urandom_range(0, 99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
            item_tag  = TAG_W'($urandom);
            if (item_kind == KIND_FREE) begin
               // mostly release held tags; some already free or out of range
               pick     = $urandom_range(0, 99);
               used_tag = sb.pick_used();
               if (pick < 70 && used_tag >= 0)
                  item_tag = TAG_W'(used_tag);
               else if (pick < 85)
                  item_tag = TAG_W'($urandom_range(0, sb.tag_limit - 1));
            end
            offer_item(item_kind, REQ_W'($urandom), item_tag);
         end
      end

      // wait out the last results, then wait on for strays
      req_valid <= 1'b0;
      for (int c = 0; c < 4000 && sb.grants_due.size() != 0; c++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.grants_due.size() != 0)
         sb.report("results still owed at end", sb.grants_due.size(), 0);

      $display("Covered %0d grants (%0d refused on a full pool), %0d frees (%0d out of range)",
               sb.n_alloc, sb.n_denied, sb.n_freed, sb.n_bad_free);
      $display("over %0d tag limits, with a %0d-cycle result hold that backed up requests",
               sb.n_settings, LONG_HOLD);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hang guard
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
